### hw/rtl/sgr_pkg.sv
// Shared types, character codes and color helpers for the SGR color filter.
`timescale 1ns / 1ps

package sgr_pkg;

  typedef enum logic [1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_ESC     = 2'd1,
    MODE_PARAMS  = 2'd2,
    MODE_LITERAL = 2'd3
  } mode_t;

  typedef struct packed {
    logic [3:0] fg;
    logic [3:0] bg;
  } colors_t;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  localparam logic [7:0] FG_LO     = 8'd30;
  localparam logic [7:0] FG_HI     = 8'd37;
  localparam logic [7:0] FG_BR_LO  = 8'd90;
  localparam logic [7:0] FG_BR_HI  = 8'd97;
  localparam logic [7:0] BG_LO     = 8'd40;
  localparam logic [7:0] BG_HI     = 8'd47;
  localparam logic [7:0] BG_BR_LO  = 8'd100;
  localparam logic [7:0] BG_BR_HI  = 8'd107;
  localparam logic [7:0] PARAM_MAX = 8'd255;

  localparam logic [3:0] RESET_FG = 4'd7;
  localparam logic [3:0] RESET_BG = 4'd0;

  function automatic colors_t apply_code(input logic [7:0] code, input colors_t cur);
    colors_t    res;
    logic [7:0] diff;
    begin
      res  = cur;
      diff = 8'd0;
      if (code >= FG_LO && code <= FG_HI) begin
        diff   = code - FG_LO;
        res.fg = diff[3:0];
      end else if (code >= FG_BR_LO && code <= FG_BR_HI) begin
        diff   = code - FG_BR_LO;
        res.fg = {1'b1, diff[2:0]};
      end else if (code >= BG_LO && code <= BG_HI) begin
        diff   = code - BG_LO;
        res.bg = diff[3:0];
      end else if (code >= BG_BR_LO && code <= BG_BR_HI) begin
        diff   = code - BG_BR_LO;
        res.bg = {1'b1, diff[2:0]};
      end
      return res;
    end
  endfunction

endpackage

### hw/rtl/ansi_sgr_color_filter_core.sv
// Top level of the SGR color filter: escape parser, color state and output register.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+------------------------------
//   byte    | in        | byte_valid, byte_stall | byte_in[7:0]
//   char    | out       | char_valid, char_stall | char_out[7:0], fg_color[3:0],
//           |           |                        | bg_color[3:0]
//
// One byte per cycle sustained while the output is not stalled; a printed byte
// passes from the input register through the parser into the result register.
// NUL, an ESC in normal mode, sequence bytes and a dropped 'm' give no output item.
// Synchronous reset empties both registers, returns to normal mode and sets
// colors to light grey on black.
// A stalled output item holds; byte_stall rises only while the input register
// is full and the result register cannot take a new item.
`timescale 1ns / 1ps

module ansi_sgr_color_filter_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] byte_in,
  output logic       char_valid,
  input  logic       char_stall,
  output logic [7:0] char_out,
  output logic [3:0] fg_color,
  output logic [3:0] bg_color
);

  import sgr_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_byte;

  mode_t      mode, mode_next;
  colors_t    current, current_next;
  colors_t    pending, pending_next;
  logic [7:0] param_value, param_value_next;
  logic       param_has_digit, param_has_digit_next;

  logic       out_free;
  logic       fire;
  logic       emit;
  logic       is_digit;
  logic [11:0] param_sum;
  colors_t    applied;

  assign out_free   = !char_valid || !char_stall;
  assign fire       = s1_valid && out_free;
  assign byte_stall = s1_valid && !out_free;

  assign is_digit  = (s1_byte >= CH_ZERO) && (s1_byte <= CH_NINE);
  assign param_sum = {1'b0, param_value, 3'b000} + {3'b000, param_value, 1'b0}
                   + {8'd0, s1_byte[3:0]};
  assign applied   = apply_code(param_value, pending);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!byte_stall) begin
      s1_valid <= byte_valid;
    end
    if (!byte_stall) begin
      s1_byte <= byte_in;
    end
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= MODE_NORMAL;
      current         <= '{fg: RESET_FG, bg: RESET_BG};
      pending         <= '0;
      param_value     <= 8'd0;
      param_has_digit <= 1'b0;
    end else if (fire) begin
      mode            <= mode_next;
      current         <= current_next;
      pending         <= pending_next;
      param_value     <= param_value_next;
      param_has_digit <= param_has_digit_next;
    end
  end

  always_comb begin
    mode_next            = mode;
    current_next         = current;
    pending_next         = pending;
    param_value_next     = param_value;
    param_has_digit_next = param_has_digit;
    emit                 = 1'b0;
    if (s1_byte == CH_NUL) begin
      mode_next = MODE_NORMAL;
    end else begin
      unique case (mode)
        MODE_NORMAL: begin
          if (s1_byte == CH_ESC) begin
            mode_next = MODE_ESC;
          end else begin
            emit = 1'b1;
          end
        end
        MODE_ESC: begin
          if (s1_byte == CH_LBRACKET) begin
            mode_next            = MODE_PARAMS;
            pending_next         = current;
            param_value_next     = 8'd0;
            param_has_digit_next = 1'b0;
          end else begin
            mode_next = MODE_NORMAL;
            emit      = 1'b1;
          end
        end
        MODE_PARAMS: begin
          if (is_digit) begin
            param_value_next     = (param_sum > {4'd0, PARAM_MAX}) ? PARAM_MAX
                                                                   : param_sum[7:0];
            param_has_digit_next = 1'b1;
          end else if (s1_byte == CH_SEMI) begin
            pending_next         = applied;
            param_value_next     = 8'd0;
            param_has_digit_next = 1'b0;
          end else if (s1_byte == CH_M) begin
            if (param_has_digit) begin
              pending_next = applied;
              current_next = applied;
              mode_next    = MODE_NORMAL;
            end else begin
              mode_next = MODE_LITERAL;
            end
          end
        end
        MODE_LITERAL: begin
          mode_next = MODE_NORMAL;
          emit      = 1'b1;
        end
        default: begin
          mode_next = MODE_NORMAL;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (out_free) begin
      char_valid <= fire && emit;
    end
    if (fire && emit) begin
      char_out <= s1_byte;
      fg_color <= current.fg;
      bg_color <= current.bg;
    end
  end

endmodule

### hw/rtl/sgr_checker.sv
// Port-level checker for the SGR color filter, bound to the top level.
`timescale 1ns / 1ps

module sgr_checker (
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic       char_valid,
  input logic       char_stall,
  input logic [7:0] char_out,
  input logic [3:0] fg_color,
  input logic [3:0] bg_color
);

  import sgr_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> !char_valid)
    else $error("output item present right after reset");

  a_no_nul_out: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> char_out != CH_NUL)
    else $error("NUL byte delivered as an item");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(char_valid) |-> $past(byte_valid && !byte_stall, 2))
    else $error("output item without an input item two cycles before");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_out)
      && $stable(fg_color) && $stable(bg_color))
    else $error("stalled output item changed");

endmodule

bind ansi_sgr_color_filter_core sgr_checker u_sgr_checker (
  .clk        (clk),
  .rst        (rst),
  .byte_valid (byte_valid),
  .byte_stall (byte_stall),
  .char_valid (char_valid),
  .char_stall (char_stall),
  .char_out   (char_out),
  .fg_color   (fg_color),
  .bg_color   (bg_color)
);

### test/ansi_sgr_color_filter_core_tb.sv
// Self-checking testbench for the SGR color filter core: table-driven and random byte streams.
`timescale 1ns / 1ps

module ansi_sgr_color_filter_core_tb;
  import sgr_pkg::*;

  localparam int DIR_N       = 26;
  localparam int RAND_ITEMS  = 400;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
  } glyph_t;

  typedef struct packed {
    logic [7:0] b;
    logic       typed;
    glyph_t     glyph;
  } row_t;

  localparam glyph_t NO_GLYPH = '0;

  logic       clk;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  logic [7:0] byte_in = 8'h00;
  logic       char_valid;
  logic       char_stall = 1'b0;
  logic [7:0] char_out;
  logic [3:0] fg_color;
  logic [3:0] bg_color;

  ansi_sgr_color_filter_core dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_in    (byte_in),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_out   (char_out),
    .fg_color   (fg_color),
    .bg_color   (bg_color)
  );

  row_t   directed_rows [DIR_N];
  row_t   byte_stream [$];
  glyph_t glyphs_due [$];
  int     sent_count = 0;
  int     rand_count = 1;
  int     errors = 0;
  int     cycles = 0;
  int     send_idle_pct;
  int     recv_stall_pct;

  // Predictor state
  mode_t      pmode = MODE_NORMAL;
  logic [3:0] shown_fg = RESET_FG;
  logic [3:0] shown_bg = RESET_BG;
  logic [3:0] next_fg = 4'd0;
  logic [3:0] next_bg = 4'd0;
  logic [7:0] number = 8'd0;
  logic       number_has_digit = 1'b0;

  function automatic void select_color(input logic [7:0] code);
    if (code >= FG_LO && code <= FG_HI) next_fg = 4'(code - FG_LO);
    else if (code >= FG_BR_LO && code <= FG_BR_HI) next_fg = 4'(code - FG_BR_LO + 8);
    else if (code >= BG_LO && code <= BG_HI) next_bg = 4'(code - BG_LO);
    else if (code >= BG_BR_LO && code <= BG_BR_HI) next_bg = 4'(code - BG_BR_LO + 8);
  endfunction

  function automatic bit filter_byte(input logic [7:0] b, output glyph_t g);
    int acc;
    g = '{ch: b, fg: shown_fg, bg: shown_bg};
    if (b == CH_NUL) begin
      pmode = MODE_NORMAL;
      return 1'b0;
    end
    case (pmode)
      MODE_NORMAL: begin
        if (b == CH_ESC) begin
          pmode = MODE_ESC;
          return 1'b0;
        end
        return 1'b1;
      end
      MODE_ESC: begin
        if (b == CH_LBRACKET) begin
          pmode = MODE_PARAMS;
          next_fg = shown_fg;
          next_bg = shown_bg;
          number = 8'd0;
          number_has_digit = 1'b0;
          return 1'b0;
        end
        pmode = MODE_NORMAL;
        return 1'b1;
      end
      MODE_PARAMS: begin
        if (b >= CH_ZERO && b <= CH_NINE) begin
          acc = int'(number) * 10 + int'(b - CH_ZERO);
          number = (acc > 255) ? PARAM_MAX : 8'(acc);
          number_has_digit = 1'b1;
        end else if (b == CH_SEMI) begin
          select_color(number);
          number = 8'd0;
          number_has_digit = 1'b0;
        end else if (b == CH_M) begin
          if (number_has_digit) begin
            select_color(number);
            shown_fg = next_fg;
            shown_bg = next_bg;
            pmode = MODE_NORMAL;
          end else begin
            pmode = MODE_LITERAL;
          end
        end
        return 1'b0;
      end
      default: begin
        pmode = MODE_NORMAL;
        return 1'b1;
      end
    endcase
  endfunction

  task automatic push_byte(input logic [7:0] b);
    byte_stream.push_back({b, 1'b0, NO_GLYPH});
  endtask

  task automatic push_number(input int n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_sgr_sequence();
    int         nparams;
    logic [7:0] noise;
    push_byte(CH_ESC);
    push_byte(CH_LBRACKET);
    nparams = $urandom_range(1, 3);
    for (int p = 0; p < nparams; p++) begin
      if (p != 0) push_byte(CH_SEMI);
      case ($urandom_range(7))
        0: push_number(FG_LO + $urandom_range(7));
        1: push_number(FG_BR_LO + $urandom_range(7));
        2: push_number(BG_LO + $urandom_range(7));
        3: push_number(BG_BR_LO + $urandom_range(7));
        4: begin
          if ($urandom_range(1)) push_byte(CH_ZERO);
          push_number($urandom_range(999));
        end
        5: ;
        6: push_number($urandom_range(99999));
        default: begin
          noise = 8'($urandom_range(1, 255));
          if ((noise >= CH_ZERO && noise <= CH_NINE) || noise == CH_SEMI || noise == CH_M)
            noise = 8'h78;
          push_byte(8'($urandom_range(3, 4)) + CH_ZERO);
          push_byte(noise);
          push_byte(8'($urandom_range(7)) + CH_ZERO);
        end
      endcase
    end
    case ($urandom_range(19))
      0: push_byte(CH_NUL);
      1, 2: begin
        push_byte(CH_SEMI);
        push_byte(CH_M);
      end
      default: push_byte(CH_M);
    endcase
    repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(1, 255)));
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always_comb begin
    int phase;
    if (sent_count < DIR_N) phase = 0;
    else phase = ((sent_count - DIR_N) * 4) / rand_count;
    if (phase > 3) phase = 3;
    send_idle_pct  = (phase == 1) ? 84 : (phase == 3) ? 36 : 0;
    recv_stall_pct = (phase == 2) ? 84 : (phase == 3) ? 36 : 0;
  end

  always @(posedge clk) begin : drive_bytes
    logic   taken;
    glyph_t g;
    if (rst) begin
      byte_valid <= 1'b0;
    end else begin
      taken = byte_valid && !byte_stall;
      if (taken) begin
        if (filter_byte(byte_stream[sent_count].b, g)) begin
          if (byte_stream[sent_count].typed) glyphs_due.push_back(byte_stream[sent_count].glyph);
          else glyphs_due.push_back(g);
        end
        sent_count++;
      end
      if (byte_valid && !taken) begin
        byte_valid <= 1'b1;
      end else if (sent_count < byte_stream.size() && $urandom_range(99) >= send_idle_pct) begin
        byte_valid <= 1'b1;
        byte_in <= byte_stream[sent_count].b;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_chars
    glyph_t e;
    if (!rst) begin
      if (char_valid && !char_stall) begin
        if (glyphs_due.size() == 0) begin
          $display("%0t: unexpected item char=%h fg=%0d bg=%0d",
                   $time, char_out, fg_color, bg_color);
          errors++;
        end else begin
          e = glyphs_due.pop_front();
          if (char_out !== e.ch || fg_color !== e.fg || bg_color !== e.bg) begin
            $display("%0t: expected char=%h fg=%0d bg=%0d, got char=%h fg=%0d bg=%0d",
                     $time, e.ch, e.fg, e.bg, char_out, fg_color, bg_color);
            errors++;
          end
        end
      end
      char_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int r;
    directed_rows = '{
      {8'h41, 1'b1, 8'h41, RESET_FG, RESET_BG},
      {8'hFF, 1'b1, 8'hFF, RESET_FG, RESET_BG},
      {CH_ESC, 1'b0, NO_GLYPH},
      {CH_LBRACKET, 1'b0, NO_GLYPH},
      {CH_NINE, 1'b0, NO_GLYPH},
      {CH_NINE, 1'b0, NO_GLYPH},
      {CH_NINE, 1'b0, NO_GLYPH},
      {CH_SEMI, 1'b0, NO_GLYPH},
      {8'h34, 1'b0, NO_GLYPH},
      {8'h78, 1'b0, NO_GLYPH},
      {CH_ZERO, 1'b0, NO_GLYPH},
      {CH_SEMI, 1'b0, NO_GLYPH},
      {CH_NINE, 1'b0, NO_GLYPH},
      {8'h37, 1'b0, NO_GLYPH},
      {CH_M, 1'b0, NO_GLYPH},
      {CH_ESC, 1'b0, NO_GLYPH},
      {8'h51, 1'b0, NO_GLYPH},
      {CH_ESC, 1'b0, NO_GLYPH},
      {CH_ESC, 1'b0, NO_GLYPH},
      {CH_ESC, 1'b0, NO_GLYPH},
      {CH_LBRACKET, 1'b0, NO_GLYPH},
      {CH_M, 1'b0, NO_GLYPH},
      {CH_ESC, 1'b0, NO_GLYPH},
      {CH_ESC, 1'b0, NO_GLYPH},
      {CH_LBRACKET, 1'b0, NO_GLYPH},
      {CH_NUL, 1'b0, NO_GLYPH}
    };
    for (int i = 0; i < DIR_N; i++) byte_stream.push_back(directed_rows[i]);

    while (byte_stream.size() < DIR_N + RAND_ITEMS) begin
      r = $urandom_range(99);
      if (r < 50) begin
        push_sgr_sequence();
      end else if (r < 75) begin
        repeat ($urandom_range(1, 8)) push_byte(8'($urandom_range(32, 126)));
      end else if (r < 87) begin
        push_byte(CH_ESC);
        push_byte(8'($urandom_range(255)));
      end else if (r < 92) begin
        push_byte(CH_NUL);
      end else begin
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(255)));
      end
    end
    rand_count = byte_stream.size() - DIR_N;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (sent_count < byte_stream.size()) @(posedge clk);
    while (glyphs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
